>>> rtl/slxfp_pkg.sv
// Shared constants and types for the sync/length/XOR frame parser.
`timescale 1ns / 1ps

package slxfp_pkg;

  // Longest frame on the wire: two sync bytes, length, payload, trailer.
  localparam int MAX_FRAME_BYTES = 11;
  localparam int MAX_LEN         = MAX_FRAME_BYTES - 4;
  localparam int LEN_W           = $clog2(MAX_LEN + 1);
  localparam int STORE_DEPTH     = 7;
  localparam int DATA_FIELDS     = 6;
  localparam int LED_MIN_LEN     = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_CODE    = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;
  localparam logic [7:0] LED_CODE_RST    = 8'h06;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_SYNC2 = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_BODY  = 4'b1000
  } phase_e;

  typedef logic [7:0] byte_t;

endpackage

>>> rtl/sync_len_xor_frame_parser.sv
// Frame parser: sync hunt, length check, running XOR and registered result.
// A result is registered and appears in the cycle after its trailer beat is accepted.
// Throughput: one byte per cycle unless a trailer beat is stalled; the phase
// register and running XOR update in the same cycle as the byte arrives.
// A trailer beat is held off only while a previous result is still stalled.
// Reset: parser hunts for the first sync byte, sync and LED registers take
// 0x55, 0xAA and 0x06; the payload store is not cleared.
`timescale 1ns / 1ps

module sync_len_xor_frame_parser import slxfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           func_code_o,
  output logic [2:0]           payload_len_o,
  output logic [7:0]           data_zero_o,
  output logic [7:0]           data_one_o,
  output logic [7:0]           data_two_o,
  output logic [7:0]           data_three_o,
  output logic [7:0]           data_four_o,
  output logic [7:0]           data_five_o,
  output logic                 led_cmd_valid_o,
  output logic [7:0]           led_number_o,
  output logic                 led_on_o
);

  byte_t sync_first_q, sync_second_q, led_code_q;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] frame_len_q, frame_len_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  byte_t            xor_q, xor_d;
  byte_t            store_q [STORE_DEPTH];

  logic  out_valid_q, out_valid_d;
  byte_t func_q, led_num_q;
  logic [2:0] len_out_q;
  byte_t data_q [DATA_FIELDS];
  byte_t data_d [DATA_FIELDS];
  logic  led_valid_q, led_on_q, led_valid_d;

  logic  in_acc, trailer, emit, store_we;
  logic  len_ok;
  byte_t len_ext;

  assign len_ext  = 8'(frame_len_q);
  assign trailer  = (phase_q == PH_BODY) && (pos_q == frame_len_q);
  // Hold only a beat that could produce a result while the output is blocked.
  assign in_stall_o = out_valid_q && out_stall_i && trailer;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign len_ok   = (rx_byte_i != 8'd0) && (rx_byte_i <= 8'(MAX_LEN));
  assign emit     = in_acc && trailer && (rx_byte_i == xor_q);
  assign store_we = in_acc && (phase_q == PH_BODY) && !trailer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      led_code_q    <= LED_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        CFG_LED_CODE:    led_code_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    pos_d       = pos_q;
    xor_d       = xor_q;
    if (in_acc) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == sync_first_q) begin
            xor_d   = rx_byte_i;
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx_byte_i == sync_second_q) begin
            xor_d   = xor_q ^ rx_byte_i;
            phase_d = PH_LEN;
          end else if (rx_byte_i == sync_first_q) begin
            // Resync onto the repeated first sync byte.
            xor_d   = rx_byte_i;
            phase_d = PH_SYNC2;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (len_ok) begin
            xor_d       = xor_q ^ rx_byte_i;
            frame_len_d = LEN_W'(rx_byte_i);
            pos_d       = '0;
            phase_d     = PH_BODY;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (trailer) begin
            phase_d = PH_HUNT;
          end else begin
            xor_d = xor_q ^ rx_byte_i;
            pos_d = pos_q + LEN_W'(1);
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      frame_len_q <= '0;
      pos_q       <= '0;
      xor_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      pos_q       <= pos_d;
      xor_q       <= xor_d;
    end
  end

  // Every payload byte enters the XOR and is stored at its position; STORE_DEPTH covers MAX_LEN.
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < STORE_DEPTH; e++) begin
      if (store_we && (8'(pos_q) == 8'(e))) begin
        store_q[e] <= rx_byte_i;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < DATA_FIELDS; k++) begin
      data_d[k] = (8'(k + 1) < len_ext) ? store_q[k+1] : 8'd0;
    end
    led_valid_d = (store_q[0] == led_code_q) && (len_ext >= 8'(LED_MIN_LEN));
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      func_q      <= store_q[0];
      len_out_q   <= 3'(frame_len_q);
      data_q      <= data_d;
      led_valid_q <= led_valid_d;
      led_num_q   <= led_valid_d ? store_q[1] : 8'd0;
      led_on_q    <= led_valid_d && (store_q[2] != 8'd0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign func_code_o     = func_q;
  assign payload_len_o   = len_out_q;
  assign data_zero_o     = data_q[0];
  assign data_one_o      = data_q[1];
  assign data_two_o      = data_q[2];
  assign data_three_o    = data_q[3];
  assign data_four_o     = data_q[4];
  assign data_five_o     = data_q[5];
  assign led_cmd_valid_o = led_valid_q;
  assign led_number_o    = led_num_q;
  assign led_on_o        = led_on_q;

  a_stall_only_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (phase_q == PH_BODY))
    else $error("input stalled outside the trailer beat");

  a_result_from_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || !out_stall_i) ##1 out_valid_q |-> $past(in_acc && trailer))
    else $error("result without an accepted trailer beat");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (frame_len_q != '0) && (pos_q <= frame_len_q))
    else $error("body phase with bad length or position");

  a_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && trailer |=> (phase_q == PH_HUNT))
    else $error("parser did not return to hunting after trailer");

endmodule

>>> dv/tb_sync_len_xor_frame_parser.sv
// Self-checking testbench for the sync/length/XOR frame parser.
`timescale 1ns / 1ps

module tb_sync_len_xor_frame_parser;
  import slxfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENT_BYTES  = 265;
  localparam int SEGMENTS       = 6;

  typedef struct {
    byte_t      func;
    logic [2:0] len;
    byte_t      data [DATA_FIELDS];
    logic       led_valid;
    byte_t      led_num;
    logic       led_on;
  } frame_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           func_code;
  logic [2:0]           payload_len;
  logic [7:0]           data_out [DATA_FIELDS];
  logic                 led_cmd_valid;
  logic [7:0]           led_number;
  logic                 led_on;

  // register shadows and parser state mirror
  byte_t  sync_first_r = SYNC_FIRST_RST;
  byte_t  sync_second_r = SYNC_SECOND_RST;
  byte_t  led_code_r = LED_CODE_RST;
  phase_e parse_phase = PH_HUNT;
  int     frame_len = 0;
  int     bytes_left = 0;
  int     body_pos = 0;
  byte_t  xor_acc = '0;
  byte_t  payload_store [STORE_DEPTH] = '{default: '0};

  byte_t  tx_bytes [$];
  frame_t expected_frames [$];

  int send_idle_pct = 21;
  int recv_stall_pct = 88;
  int err_count = 0;
  int bytes_sent = 0;
  int frames_checked = 0;
  int led_frames = 0;
  int idle_cycles = 0;

  sync_len_xor_frame_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .func_code_o     (func_code),
    .payload_len_o   (payload_len),
    .data_zero_o     (data_out[0]),
    .data_one_o      (data_out[1]),
    .data_two_o      (data_out[2]),
    .data_three_o    (data_out[3]),
    .data_four_o     (data_out[4]),
    .data_five_o     (data_out[5]),
    .led_cmd_valid_o (led_cmd_valid),
    .led_number_o    (led_number),
    .led_on_o        (led_on)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the parser mirror by one byte; queue a frame when the trailer checks.
  function automatic void parse_rx_byte(byte_t b);
    frame_t f;
    case (parse_phase)
      PH_HUNT: begin
        if (b == sync_first_r) begin
          xor_acc = b;
          parse_phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // second sync wins when both registers hold the same value
        if (b == sync_second_r) begin
          xor_acc ^= b;
          parse_phase = PH_LEN;
        end else if (b == sync_first_r) begin
          xor_acc = b;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (b == 8'h00 || int'(b) + 4 > MAX_FRAME_BYTES) begin
          parse_phase = PH_HUNT;
        end else begin
          xor_acc ^= b;
          frame_len = int'(b);
          bytes_left = int'(b) + 1;
          body_pos = 0;
          parse_phase = PH_BODY;
        end
      end
      default: begin
        if (bytes_left > 1) begin
          if (body_pos < STORE_DEPTH) payload_store[body_pos] = b;
          body_pos++;
          xor_acc ^= b;
          bytes_left--;
        end else begin
          bytes_left = 0;
          parse_phase = PH_HUNT;
          if (b == xor_acc) begin
            f.func = payload_store[0];
            f.len = 3'(frame_len);
            for (int k = 0; k < DATA_FIELDS; k++) begin
              f.data[k] = (k < frame_len - 1) ? payload_store[k + 1] : 8'h00;
            end
            f.led_valid = (payload_store[0] == led_code_r) && (frame_len >= LED_MIN_LEN);
            f.led_num = f.led_valid ? payload_store[1] : 8'h00;
            f.led_on = f.led_valid && (payload_store[2] != 8'h00);
            expected_frames.push_back(f);
          end
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t, frame %0d, %s: got 0x%0h, want 0x%0h",
             $realtime, frames_checked, what, got, want);
    err_count++;
  endtask

  // sender: hold a stalled beat, otherwise offer the next byte or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_rx_byte(rx_byte);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each frame beat against the oldest prediction
  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          flag_mismatch("frame with nothing expected", func_code, 0);
        end else begin
          want = expected_frames.pop_front();
          if (func_code !== want.func) flag_mismatch("func_code", func_code, want.func);
          if (payload_len !== want.len) flag_mismatch("payload_len", payload_len, want.len);
          for (int k = 0; k < DATA_FIELDS; k++) begin
            if (data_out[k] !== want.data[k]) begin
              flag_mismatch($sformatf("data byte %0d", k), data_out[k], want.data[k]);
            end
          end
          if (led_cmd_valid !== want.led_valid) begin
            flag_mismatch("led_cmd_valid", led_cmd_valid, want.led_valid);
          end
          if (led_number !== want.led_num) flag_mismatch("led_number", led_number, want.led_num);
          if (led_on !== want.led_on) flag_mismatch("led_on", led_on, want.led_on);
          if (want.led_valid) led_frames++;
        end
        frames_checked++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d frames still pending",
                 WATCHDOG_LIMIT, expected_frames.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, byte_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC_FIRST: sync_first_r = value;
      CFG_SYNC_SECOND: sync_second_r = value;
      default: led_code_r = value;
    endcase
  endtask

  // Queue sync, sync, length; a length out of range ends the frame there.
  task automatic queue_frame(int len, byte_t func, bit bad_trailer, bit dup_first);
    byte_t acc;
    byte_t body;
    if (dup_first) tx_bytes.push_back(sync_first_r);
    tx_bytes.push_back(sync_first_r);
    tx_bytes.push_back(sync_second_r);
    tx_bytes.push_back(byte_t'(len));
    if (len >= 1 && len <= MAX_LEN) begin
      acc = sync_first_r ^ sync_second_r ^ byte_t'(len);
      for (int i = 0; i < len; i++) begin
        if (i == 0) body = func;
        else if (i == 2 && $urandom_range(2) == 0) body = 8'h00;
        else body = byte_t'($urandom);
        acc ^= body;
        tx_bytes.push_back(body);
      end
      tx_bytes.push_back(bad_trailer ? acc ^ byte_t'($urandom_range(1, 255)) : acc);
    end
  endtask

  task automatic queue_random_frame();
    int    pick;
    byte_t func;
    pick = $urandom_range(99);
    func = ($urandom_range(2) == 0) ? led_code_r : byte_t'($urandom);
    if (pick < 62) begin
      queue_frame($urandom_range(1, MAX_LEN), func, 1'b0, 1'b0);
    end else if (pick < 72) begin
      queue_frame($urandom_range(1, MAX_LEN), func, 1'b1, 1'b0);
    end else if (pick < 80) begin
      queue_frame($urandom_range(1, MAX_LEN), func, 1'b0, 1'b1);
    end else if (pick < 86) begin
      queue_frame(($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_LEN + 1, 255),
                  func, 1'b0, 1'b0);
    end else if (pick < 92) begin
      // first sync followed by an arbitrary byte
      tx_bytes.push_back(sync_first_r);
      tx_bytes.push_back(byte_t'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) tx_bytes.push_back(byte_t'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() > 0 || in_valid || expected_frames.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: max-length LED frame, repeated first sync, both bad lengths,
    // bad trailer
    queue_frame(MAX_LEN, LED_CODE_RST, 1'b0, 1'b0);
    queue_frame(1, 8'hFF, 1'b0, 1'b1);
    queue_frame(0, 8'h00, 1'b0, 1'b0);
    queue_frame(MAX_LEN + 1, 8'h00, 1'b0, 1'b0);
    queue_frame(1, 8'h00, 1'b1, 1'b0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg > 0) begin
        wait_idle();
        case (seg)
          1: begin
            write_reg(CFG_SYNC_FIRST, 8'h00);
            write_reg(CFG_SYNC_SECOND, 8'hFF);
            write_reg(CFG_LED_CODE, 8'h00);
          end
          2: begin
            write_reg(CFG_SYNC_FIRST, 8'hFF);
            write_reg(CFG_SYNC_SECOND, 8'h00);
            write_reg(CFG_LED_CODE, 8'hFF);
          end
          3: begin
            // identical sync bytes
            write_reg(CFG_SYNC_FIRST, 8'h3C);
            write_reg(CFG_SYNC_SECOND, 8'h3C);
            write_reg(CFG_LED_CODE, byte_t'($urandom));
          end
          4: begin
            write_reg(CFG_SYNC_FIRST, byte_t'($urandom));
            write_reg(CFG_SYNC_SECOND, byte_t'($urandom));
            write_reg(CFG_LED_CODE, byte_t'($urandom));
          end
          default: begin
            write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RST);
            write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
            write_reg(CFG_LED_CODE, LED_CODE_RST);
          end
        endcase
      end
      // receiver stalls first, then sender-side gaps, then full rate
      if (seg < 2) begin
        send_idle_pct = 21;
        recv_stall_pct = 88;
      end else if (seg < 4) begin
        send_idle_pct = 88;
        recv_stall_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      target = tx_bytes.size() + SEGMENT_BYTES;
      while (tx_bytes.size() < target) queue_random_frame();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_frames.size() != 0) begin
      flag_mismatch("frames never produced", expected_frames.size(), 0);
    end
    $display("Sent %0d bytes under %0d register settings and three idle patterns;",
             bytes_sent, SEGMENTS);
    $display("checked %0d frames, %0d of them LED commands", frames_checked, led_frames);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
